[design/pbis_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbis_pkg
// Shared types, widths and codes of the packet buffer id store.
// ----------------------------------------------------------------------------
package pbis_pkg;

   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int ID_W        = 32;
   localparam int HANDLE_W    = 32;
   localparam int TIME_W      = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int MAXE_W      = 5;
   localparam int EXP_W       = 16;
   localparam int OCC_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CMP_W       = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ID_W-1:0]   ID_LIMIT   = 32'hffff_ffff;
   localparam logic [ID_W-1:0]   ID_RESET   = 32'd1;
   localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd16;
   localparam logic [EXP_W-1:0]  EXP_RESET  = 16'd60;

   localparam logic [MODE_W-1:0] MODE_STORE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RETRIEVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPIRATION  = 2'd1;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_RETRIEVE,
      OP_CHECK,
      OP_NOP
   } op_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [HANDLE_W-1:0] handle;
      logic [ID_W-1:0]     query;
      logic [TIME_W-1:0]   now;
   } item_type;

   // queue side handshake between front and back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage
`default_nettype wire

[design/pbis_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbis_front
// Accepts requests, decodes the mode and holds them in a short queue.
// ----------------------------------------------------------------------------
module pbis_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pbis_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [pbis_pkg::HANDLE_W-1:0] req_packet_handle,
   input  wire logic [pbis_pkg::ID_W-1:0]     req_query_id,
   input  wire logic [pbis_pkg::TIME_W-1:0]   req_now_seconds,
   output pbis_pkg::queue_out_type            queue_out,
   input  wire logic                          queue_pop
);
   import pbis_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   item_type            decoded;
   logic                push;
   logic                pop;

   always_comb begin
      case (req_mode)
         MODE_STORE:    decoded.op = OP_STORE;
         MODE_RETRIEVE: decoded.op = OP_RETRIEVE;
         MODE_CHECK:    decoded.op = OP_CHECK;
         default:       decoded.op = OP_NOP;
      endcase
      decoded.handle = req_packet_handle;
      decoded.query  = req_query_id;
      decoded.now    = req_now_seconds;
   end

   assign req_ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = queue_pop && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign queue_out.valid = (fill_ff != '0);
   assign queue_out.item  = slot_ff[rd_ptr_ff];

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("queue fill exceeds depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == QFILL_W'(QUEUE_DEPTH)) |-> !push)
      else $error("push into full queue");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + QFILL_W'(1)))
      else $error("queue fill lost a push");

endmodule
`default_nettype wire

[design/pbis_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbis_back
// Holds the ordered entries and config, executes one request at a time.
// ----------------------------------------------------------------------------
module pbis_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pbis_pkg::queue_out_type          queue_out,
   output logic                                  queue_pop,
   input  wire logic                             csr_valid,
   input  wire logic [pbis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pbis_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [pbis_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pbis_pkg::ID_W-1:0]             rsp_result_id,
   output logic [pbis_pkg::HANDLE_W-1:0]         rsp_result_handle,
   output logic                                  rsp_expired,
   output logic [pbis_pkg::OCC_W-1:0]            rsp_occupancy
);
   import pbis_pkg::*;

   // entry storage, no reset: only slots below the count are ever read
   logic [ID_W-1:0]     ids_ff     [DEPTH];
   logic [HANDLE_W-1:0] handles_ff [DEPTH];
   logic [TIME_W-1:0]   times_ff   [DEPTH];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ID_W-1:0]     id_ctr_ff, id_ctr_in;
   logic [MAXE_W-1:0]   max_entries_ff;
   logic [EXP_W-1:0]    expiration_ff;

   back_state_type      state_ff, state_in;
   item_type            cur_ff;
   logic [DEPTH-1:0]    match_ff, match_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [HANDLE_W-1:0] rhandle_ff, rhandle_in;
   logic                expired_ff, expired_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic                load;
   logic                commit;
   logic [CMP_W-1:0]    limit;
   logic                full;
   logic [ID_W-1:0]     next_id;
   logic [DEPTH-1:0]    first_hot;
   logic [DEPTH-1:0]    shift_mask;
   logic                found;
   logic [HANDLE_W-1:0] found_handle;
   logic [TIME_W:0]     age;
   logic                is_expired;
   logic                do_store;
   logic                do_remove;

   // ---- control FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (queue_out.valid) begin
               state_in = BACK_EXEC;
            end
         end
         BACK_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      load   = 1'b0;
      commit = 1'b0;
      case (state_ff)
         BACK_IDLE: load   = queue_out.valid;
         BACK_EXEC: commit = !rsp_valid_ff || rsp_ready;
         default: begin
            load   = 1'b0;
            commit = 1'b0;
         end
      endcase
   end

   assign queue_pop = load;

   // ---- load (BACK_IDLE): id compare over live slots
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (ids_ff[i] == queue_out.item.query);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff   <= queue_out.item;
         match_ff <= match_in;
      end
   end

   // ---- BACK_EXEC: decide and commit
   always_comb begin
      limit = (CMP_W'(max_entries_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                       : CMP_W'(max_entries_ff);
      full    = CMP_W'(count_ff) >= limit;
      next_id = (id_ctr_ff + ID_W'(1) == ID_LIMIT) ? ID_RESET : id_ctr_ff + ID_W'(1);

      // lowest match and everything from it upward
      first_hot  = match_ff & ~(match_ff - DEPTH'(1));
      shift_mask = first_hot | ~(match_ff ^ (match_ff - DEPTH'(1)));
      found      = |match_ff;
      found_handle = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_handle = found_handle | (handles_ff[i] & {HANDLE_W{first_hot[i]}});
      end

      age        = {1'b0, cur_ff.now} - {1'b0, times_ff[0]};
      is_expired = (count_ff != '0) && !age[TIME_W] &&
                   (age[TIME_W-1:0] > TIME_W'(expiration_ff));

      do_store  = commit && (cur_ff.op == OP_STORE) && !full;
      do_remove = commit && (cur_ff.op == OP_RETRIEVE) && found;

      status_in  = STATUS_OK;
      rid_in     = '0;
      rhandle_in = '0;
      expired_in = 1'b0;
      count_in   = count_ff;
      id_ctr_in  = id_ctr_ff;
      case (cur_ff.op)
         OP_STORE: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               rid_in    = next_id;
               id_ctr_in = next_id;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         OP_RETRIEVE: begin
            if (found) begin
               rhandle_in = found_handle;
               count_in   = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_CHECK: begin
            if (is_expired) begin
               expired_in = 1'b1;
               rid_in     = ids_ff[0];
            end
         end
         default: status_in = STATUS_OK;
      endcase
      occ_in = OCC_W'(count_in);

      rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // ---- storage: append at the tail, close the gap on removal
   for (genvar j = 0; j < DEPTH; j++) begin : g_entry
      always_ff @(posedge clock) begin
         if (do_store && (count_ff[IDX_W-1:0] == IDX_W'(j))) begin
            ids_ff[j]     <= next_id;
            handles_ff[j] <= cur_ff.handle;
            times_ff[j]   <= cur_ff.now;
         end else if (do_remove && shift_mask[j]) begin
            if (j < DEPTH - 1) begin
               ids_ff[j]     <= ids_ff[(j + 1) % DEPTH];
               handles_ff[j] <= handles_ff[(j + 1) % DEPTH];
               times_ff[j]   <= times_ff[(j + 1) % DEPTH];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BACK_IDLE;
         count_ff       <= '0;
         id_ctr_ff      <= ID_RESET;
         max_entries_ff <= MAXE_RESET;
         expiration_ff  <= EXP_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff  <= count_in;
            id_ctr_ff <= id_ctr_in;
         end
         if (csr_valid && (csr_index == CSR_MAX_ENTRIES)) begin
            max_entries_ff <= csr_data[MAXE_W-1:0];
         end
         if (csr_valid && (csr_index == CSR_EXPIRATION)) begin
            expiration_ff <= csr_data[EXP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff  <= status_in;
         rid_ff     <= rid_in;
         rhandle_ff <= rhandle_in;
         expired_ff <= expired_in;
         occ_ff     <= occ_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_id     = rid_ff;
   assign rsp_result_handle = rhandle_ff;
   assign rsp_expired       = expired_ff;
   assign rsp_occupancy     = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");
   a_id_legal: assert property (@(posedge clock) disable iff (reset)
      (id_ctr_ff != '0) && (id_ctr_ff != ID_LIMIT))
      else $error("id counter holds a reserved value");
   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      do_store |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("store did not grow the count");
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed response not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !commit)
      else $error("pending response overwritten");

endmodule
`default_nettype wire

[design/packet_buffer_id_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_buffer_id_store
// Ordered store of packet handles keyed by generated ids, with expiry check.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  mode, packet_handle, query_id,
//                                             now_seconds
//  rsp_     out        rsp_valid / rsp_ready  status, result_id, result_handle,
//                                             expired, occupancy
//  csr_     in         csr_valid / csr_ready  index (0 max_entries,
//                                             1 expiration_seconds), data
//
//  Each request passes two steps in the back end: the parallel id compare
//  against the live slots on load, then the commit (append, shift-compact or
//  age check) into the response register. A new request is loaded only after
//  the last one has committed; commit waits while an earlier response is held.
//  The front end takes requests into a 2-entry queue, so requests are
//  accepted while a response waits on a stalled rsp_ready.
//  Reset is synchronous: count 0, id counter 1, max_entries 16, expiration
//  60 s. Entry storage is not reset; no clearing pass is needed.
//  csr_ready is always high; config should only change while idle.
//
module packet_buffer_id_store (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [pbis_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [pbis_pkg::HANDLE_W-1:0]    req_packet_handle,
   input  wire logic [pbis_pkg::ID_W-1:0]        req_query_id,
   input  wire logic [pbis_pkg::TIME_W-1:0]      req_now_seconds,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [pbis_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pbis_pkg::ID_W-1:0]             rsp_result_id,
   output logic [pbis_pkg::HANDLE_W-1:0]         rsp_result_handle,
   output logic                                  rsp_expired,
   output logic [pbis_pkg::OCC_W-1:0]            rsp_occupancy,
   // config write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pbis_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pbis_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pbis_pkg::*;

   queue_out_type queue_out;
   logic          queue_pop;

   // config registers live in the back end and take a write every cycle
   assign csr_ready = 1'b1;

   // front: decode mode, buffer requests
   pbis_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_packet_handle (req_packet_handle),
      .req_query_id      (req_query_id),
      .req_now_seconds   (req_now_seconds),
      .queue_out         (queue_out),
      .queue_pop         (queue_pop)
   );

   // back: entry storage, id counter, execution and response register
   pbis_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_out         (queue_out),
      .queue_pop         (queue_pop),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_handle (rsp_result_handle),
      .rsp_expired       (rsp_expired),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule
`default_nettype wire
